// File: rtl/p3fk_pkg.sv
// shared types, constants and arithmetic helpers for the planar three-link kinematics block
`default_nettype none
package p3fk_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    // cordic start value, gain-compensated 1.0 in Q2.30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [1:0] REG_LINK_ONE   = 2'd0;
    localparam logic [1:0] REG_LINK_TWO   = 2'd1;
    localparam logic [1:0] REG_LINK_THREE = 2'd2;

    localparam logic [15:0] LINK_RESET = 16'd256;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
        logic [1:0]         q;
    } t_lane;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic signed [31:0] cordic_atan(input int unsigned idx);
        logic signed [31:0] a;
        case (idx)
            0:  a = 32'sd536870912;
            1:  a = 32'sd316933406;
            2:  a = 32'sd167458907;
            3:  a = 32'sd85004757;
            4:  a = 32'sd42667331;
            5:  a = 32'sd21354465;
            6:  a = 32'sd10679838;
            7:  a = 32'sd5340245;
            8:  a = 32'sd2670163;
            9:  a = 32'sd1335087;
            10: a = 32'sd667544;
            11: a = 32'sd333772;
            12: a = 32'sd166886;
            13: a = 32'sd83443;
            14: a = 32'sd41722;
            15: a = 32'sd20861;
            16: a = 32'sd10430;
            17: a = 32'sd5215;
            18: a = 32'sd2608;
            19: a = 32'sd1304;
            20: a = 32'sd652;
            21: a = 32'sd326;
            22: a = 32'sd163;
            23: a = 32'sd81;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    function automatic t_lane cordic_step(input t_lane l, input int unsigned idx);
        t_lane o;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        dx = l.y >>> idx;
        dy = l.x >>> idx;
        o.q = l.q;
        if (!l.z[31]) begin
            o.x = l.x - dx;
            o.y = l.y + dy;
            o.z = l.z - cordic_atan(idx);
        end else begin
            o.x = l.x + dx;
            o.y = l.y - dy;
            o.z = l.z + cordic_atan(idx);
        end
        return o;
    endfunction

    // Q2.30 to Q1.15, round half up and saturate
    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] r;
        logic signed [15:0] o;
        t = 35'(v) + 35'sd16384;
        r = 20'(t >>> 15);
        if (r > 20'sd32767) begin
            o = 16'sh7fff;
        end else if (r < -20'sd32768) begin
            o = 16'sh8000;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

    // Q9.23 sum to Q10.8, round half up
    function automatic logic signed [20:0] rnd_q8(input logic signed [34:0] s);
        logic signed [35:0] t;
        t = 36'(s) + 36'sd16384;
        return 21'(t >>> 15);
    endfunction

    function automatic logic signed [20:0] clip(input logic signed [20:0] v,
                                                input logic signed [20:0] lo,
                                                input logic signed [20:0] hi);
        logic signed [20:0] o;
        if (v < lo) begin
            o = lo;
        end else if (v > hi) begin
            o = hi;
        end else begin
            o = v;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// File: rtl/planar_three_link_forward_kinematics_top.sv
// planar three-link arm pose and position jacobian, pipelined cordic
//
//  channel   direction  handshake               payload
//  joints    in         i_valid / o_ready       i_joint_*_angle
//  pose      out        o_valid / i_ready       o_tip_*, o_*_of_sum, o_jac_*
//  config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// one transaction per cycle while the output is not stalled; the stages are the angle sums,
// one cordic step per stage up to the capped step count, quadrant fix-up, multiply, and sum and round
// synchronous active-low reset clears valid bits and sets link lengths to 1.0
// each stage holds its transaction while the next one is full and cannot advance, so a stall on the output
// backs up stage by stage and bubbles are squeezed out
`default_nettype none
module planar_three_link_forward_kinematics_top
    import p3fk_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_joint_one_angle,
    input  wire logic signed [15:0] i_joint_two_angle,
    input  wire logic signed [15:0] i_joint_three_angle,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [18:0]      o_tip_x,
    output logic signed [18:0]      o_tip_y,
    output logic signed [17:0]      o_tip_alpha,
    output logic signed [15:0]      o_sine_of_sum,
    output logic signed [15:0]      o_cosine_of_sum,
    output logic signed [18:0]      o_jac_x_joint_one,
    output logic signed [17:0]      o_jac_x_joint_two,
    output logic signed [16:0]      o_jac_x_joint_three,
    output logic signed [18:0]      o_jac_y_joint_one,
    output logic signed [17:0]      o_jac_y_joint_two,
    output logic signed [16:0]      o_jac_y_joint_three
);

    localparam int NSTEP = (CORDIC_STEPS > CORDIC_STEPS_MAX) ? CORDIC_STEPS_MAX : CORDIC_STEPS;
    localparam int NS    = NSTEP + 4;
    localparam int SF    = NSTEP + 1;
    localparam int SM    = NSTEP + 2;
    localparam int SO    = NSTEP + 3;

    // link length registers
    logic [15:0] r_len [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len[0] <= LINK_RESET;
            r_len[1] <= LINK_RESET;
            r_len[2] <= LINK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINK_ONE:   r_len[0] <= i_cfg_data;
                REG_LINK_TWO:   r_len[1] <= i_cfg_data;
                REG_LINK_THREE: r_len[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid bits and advance chain
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_adv;

    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NS-1];

    // stage a: angle sums
    logic [15:0]        r_a_ang [3];
    logic signed [17:0] r_a_alpha;
    logic signed [17:0] w_s3;

    assign w_s3 = 18'(i_joint_one_angle) + 18'(i_joint_two_angle) + 18'(i_joint_three_angle);

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_ang[0] <= i_joint_one_angle;
            r_a_ang[1] <= i_joint_one_angle + i_joint_two_angle;
            r_a_ang[2] <= w_s3[15:0];
            r_a_alpha  <= w_s3 - 18'sd16384;
        end
    end

    // quadrant split, residual scaled to 2^-32 turn
    t_lane w_init [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [16:0] qs;
            logic [15:0] res;
            qs = {1'b0, r_a_ang[l]} + 17'd8192;
            res = r_a_ang[l] - {qs[15:14], 14'd0};
            w_init[l].q = qs[15:14];
            w_init[l].x = CORDIC_X0;
            w_init[l].y = '0;
            w_init[l].z = {res, 16'd0};
        end
    end

    // cordic stages, one step each, three lanes
    t_lane              r_cord    [NSTEP][3];
    logic signed [17:0] r_c_alpha [NSTEP];

    for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
        t_lane              w_in [3];
        logic signed [17:0] w_alpha_in;

        if (i == 0) begin : g_first
            assign w_in       = w_init;
            assign w_alpha_in = r_a_alpha;
        end else begin : g_next
            assign w_in       = r_cord[i-1];
            assign w_alpha_in = r_c_alpha[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[i+1]) begin
                for (int l = 0; l < 3; l++) begin
                    r_cord[i][l] <= cordic_step(w_in[l], i);
                end
                r_c_alpha[i] <= w_alpha_in;
            end
        end
    end

    // stage f: quadrant fix-up and rounding to Q1.15
    logic signed [15:0] r_f_sn [3];
    logic signed [15:0] r_f_cs [3];
    logic signed [17:0] r_f_alpha;
    logic signed [33:0] w_c [3];
    logic signed [33:0] w_s [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            case (r_cord[NSTEP-1][l].q)
                2'd1: begin
                    w_c[l] = -r_cord[NSTEP-1][l].y;
                    w_s[l] =  r_cord[NSTEP-1][l].x;
                end
                2'd2: begin
                    w_c[l] = -r_cord[NSTEP-1][l].x;
                    w_s[l] = -r_cord[NSTEP-1][l].y;
                end
                2'd3: begin
                    w_c[l] =  r_cord[NSTEP-1][l].y;
                    w_s[l] = -r_cord[NSTEP-1][l].x;
                end
                default: begin
                    w_c[l] = r_cord[NSTEP-1][l].x;
                    w_s[l] = r_cord[NSTEP-1][l].y;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[SF]) begin
            for (int l = 0; l < 3; l++) begin
                r_f_sn[l] <= to_q15(w_s[l]);
                r_f_cs[l] <= to_q15(w_c[l]);
            end
            r_f_alpha <= r_c_alpha[NSTEP-1];
        end
    end

    // stage m: length times trig products, Q9.23
    logic signed [32:0] r_m_sn [3];
    logic signed [32:0] r_m_cs [3];
    logic signed [15:0] r_m_sn3;
    logic signed [15:0] r_m_cs3;
    logic signed [17:0] r_m_alpha;

    always_ff @(posedge i_clk) begin
        if (w_adv[SM]) begin
            for (int l = 0; l < 3; l++) begin
                r_m_sn[l] <= $signed({1'b0, r_len[l]}) * r_f_sn[l];
                r_m_cs[l] <= $signed({1'b0, r_len[l]}) * r_f_cs[l];
            end
            r_m_sn3   <= r_f_sn[2];
            r_m_cs3   <= r_f_cs[2];
            r_m_alpha <= r_f_alpha;
        end
    end

    // stage o: sums, rounding and saturation into the output register
    logic signed [34:0] w_cx3;
    logic signed [34:0] w_cx2;
    logic signed [34:0] w_sy3;
    logic signed [34:0] w_sy2;
    logic signed [34:0] w_x;
    logic signed [34:0] w_y;
    logic signed [34:0] w_jx1;

    assign w_cx3 = 35'(r_m_cs[2]);
    assign w_cx2 = w_cx3 + 35'(r_m_cs[1]);
    assign w_sy3 = 35'(r_m_sn[2]);
    assign w_sy2 = w_sy3 + 35'(r_m_sn[1]);
    assign w_x   = w_sy2 + 35'(r_m_cs[0]);
    assign w_y   = 35'(r_m_sn[0]) - w_cx2;
    assign w_jx1 = w_cx2 - 35'(r_m_sn[0]);

    logic signed [20:0] w_x_c;
    logic signed [20:0] w_y_c;
    logic signed [20:0] w_jx1_c;
    logic signed [20:0] w_jx2_c;
    logic signed [20:0] w_jx3_c;
    logic signed [20:0] w_jy2_c;
    logic signed [20:0] w_jy3_c;

    assign w_x_c   = clip(rnd_q8(w_x),   -21'sd196608, 21'sd196607);
    assign w_y_c   = clip(rnd_q8(w_y),   -21'sd196608, 21'sd196607);
    assign w_jx1_c = clip(rnd_q8(w_jx1), -21'sd196608, 21'sd196607);
    assign w_jx2_c = clip(rnd_q8(w_cx2), -21'sd131072, 21'sd131071);
    assign w_jx3_c = clip(rnd_q8(w_cx3), -21'sd65536,  21'sd65535);
    assign w_jy2_c = clip(rnd_q8(w_sy2), -21'sd131072, 21'sd131071);
    assign w_jy3_c = clip(rnd_q8(w_sy3), -21'sd65536,  21'sd65535);

    always_ff @(posedge i_clk) begin
        if (w_adv[SO]) begin
            o_tip_x             <= w_x_c[18:0];
            o_tip_y             <= w_y_c[18:0];
            o_tip_alpha         <= r_m_alpha;
            o_sine_of_sum       <= r_m_sn3;
            o_cosine_of_sum     <= r_m_cs3;
            o_jac_x_joint_one   <= w_jx1_c[18:0];
            o_jac_x_joint_two   <= w_jx2_c[17:0];
            o_jac_x_joint_three <= w_jx3_c[16:0];
            o_jac_y_joint_one   <= w_x_c[18:0];
            o_jac_y_joint_two   <= w_jy2_c[17:0];
            o_jac_y_joint_three <= w_jy3_c[16:0];
        end
    end

    // an empty output stage means the whole pipe can move
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input not ready while output stage empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-2] && r_vld[NS-1] && !i_ready) |=> (r_vld[NS-2] && $stable(r_m_alpha)))
        else $error("stage before output lost data under stall");

endmodule
`default_nettype wire
